// ===== src/ufhb_pkg.sv =====
// ----------------------------------------------------------------------------
// ufhb_pkg
// Types and constants shared by the UDP frame header builder.
// ----------------------------------------------------------------------------
package ufhb_pkg;

   localparam int unsigned BeatCount   = 8;
   localparam int unsigned BeatIdxBits = 3;
   localparam int unsigned WordBits    = 64;
   localparam int unsigned CsrDataBits = 48;
   localparam int unsigned CsrIdxBits  = 3;

   // CSR register indexes
   localparam logic [CsrIdxBits-1:0] CsrSourceMac  = 3'd0;
   localparam logic [CsrIdxBits-1:0] CsrDestMac    = 3'd1;
   localparam logic [CsrIdxBits-1:0] CsrSourceIp   = 3'd2;
   localparam logic [CsrIdxBits-1:0] CsrDestIp     = 3'd3;
   localparam logic [CsrIdxBits-1:0] CsrSourcePort = 3'd4;
   localparam logic [CsrIdxBits-1:0] CsrDestPort   = 3'd5;

   localparam logic [BeatIdxBits-1:0] LastBeat = 3'(BeatCount - 1);

   // Fixed header fields
   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [7:0]  IpVersionIhl  = 8'h45;
   localparam logic [7:0]  IpTos         = 8'h00;
   localparam logic [15:0] IpIdent       = 16'hDEAD;
   localparam logic [15:0] IpFlagsFrag   = 16'h4000;
   localparam logic [7:0]  IpTtl         = 8'h40;
   localparam logic [7:0]  IpProtoUdp    = 8'h11;
   localparam logic [15:0] UdpChecksum   = 16'h0000;
   localparam logic [15:0] CustomMagic   = 16'h0122;
   localparam logic [15:0] IpLenBase     = 16'd50;
   localparam logic [15:0] UdpLenBase    = 16'd30;
   localparam logic [15:0] MaxPayload    = 16'd65485;

   // Sum of the constant IPv4 header words (version/TOS, id, flags, TTL/proto)
   localparam logic [19:0] IpConstSum = 20'({IpVersionIhl, IpTos}) + 20'(IpIdent)
                                      + 20'(IpFlagsFrag) + 20'({IpTtl, IpProtoUdp});

   typedef struct packed {
      logic [15:0] payload_bytes;
      logic [63:0] target_address;
   } req_type;

   typedef struct packed {
      logic [63:0] header_word;
      logic        last_word;
      logic        length_error;
   } rsp_type;

   typedef struct packed {
      logic [47:0] source_mac;
      logic [47:0] dest_mac;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } cfg_type;

   typedef struct packed {
      logic [BeatCount-1:0][WordBits-1:0] words;
      logic                               length_error;
   } hdr_type;

endpackage

// ===== src/udp_frame_header_builder_top.sv =====
// ----------------------------------------------------------------------------
// udp_frame_header_builder_top
// Ethernet / IPv4 / UDP frame header generator with a custom trailer.
// ----------------------------------------------------------------------------
// Each request (payload byte count, target address) yields a 64-byte header
// sent as eight 64-bit beats on rsp_data, one per cycle, each marked by
// rsp_valid for exactly one cycle; the earliest wire byte sits in bits 63:56
// and last_word flags the eighth beat. The receiver cannot stall: it must take
// every beat as it appears. A request is taken on a clock edge with start high
// and busy low. It lands in an input register, the header (lengths and the
// IPv4 checksum) is built from that register in one pass of logic, and the
// result is loaded into the beat register, whose first beat appears the cycle
// after. Sustained rate is set by the eight-beat output serialiser: the next
// request is held in the input register and moves on as the final beat of the
// previous one goes out, so beats run without gaps.
// length_error is set on all eight beats when the payload exceeds 65485 bytes;
// the lengths then wrap modulo 65536 and the header is still sent.
// Configuration (csr_we, csr_index, csr_wdata) is to be written only while
// no request is in flight; unmapped indexes are ignored and excess data bits
// are dropped.
// ----------------------------------------------------------------------------
module udp_frame_header_builder_top
   import ufhb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   // response channel
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   // configuration
   input  logic                   csr_we,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_wdata
);

   cfg_type cfg;
   hdr_type hdr;
   req_type req_ff;
   logic    pend_ff;
   logic    pend_in;
   logic    accept;
   logic    out_free;
   logic    load;

   ufhb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Move the held request on when the serialiser is idle or on its last beat
   assign load   = pend_ff && out_free;
   // Input register can take a request when empty or emptying this cycle
   assign busy   = pend_ff && !out_free;
   assign accept = start && !busy;

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (load) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Hold the request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   ufhb_build u_build (
      .req (req_ff),
      .cfg (cfg),
      .hdr (hdr)
   );

   ufhb_beat_out u_beat_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .hdr       (hdr),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/ufhb_csr.sv =====
// ----------------------------------------------------------------------------
// ufhb_csr
// Configuration register bank: MAC, IP and port settings.
// ----------------------------------------------------------------------------
module ufhb_csr
   import ufhb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CsrSourceMac:  cfg_in.source_mac  = csr_wdata[47:0];
            CsrDestMac:    cfg_in.dest_mac    = csr_wdata[47:0];
            CsrSourceIp:   cfg_in.source_ip   = csr_wdata[31:0];
            CsrDestIp:     cfg_in.dest_ip     = csr_wdata[31:0];
            CsrSourcePort: cfg_in.source_port = csr_wdata[15:0];
            CsrDestPort:   cfg_in.dest_port   = csr_wdata[15:0];
            default:       cfg_in = cfg_ff;  // unmapped index: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{source_mac: '0, dest_mac: '1, source_ip: '0, dest_ip: '0,
                     source_port: '0, dest_port: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/ufhb_build.sv =====
// ----------------------------------------------------------------------------
// ufhb_build
// Assemble the 64-byte header from one request and the configuration.
// ----------------------------------------------------------------------------
module ufhb_build
   import ufhb_pkg::*;
(
   input  req_type req,
   input  cfg_type cfg,
   output hdr_type hdr
);

   logic [15:0] ip_len;
   logic [15:0] udp_len;
   logic [19:0] sum_raw;
   logic [16:0] fold_1;
   logic [16:0] fold_2;
   logic [15:0] checksum;

   assign ip_len  = req.payload_bytes + IpLenBase;
   assign udp_len = req.payload_bytes + UdpLenBase;

   // One's-complement sum, carry folded back twice
   assign sum_raw = IpConstSum + 20'(ip_len)
                  + 20'(cfg.source_ip[31:16]) + 20'(cfg.source_ip[15:0])
                  + 20'(cfg.dest_ip[31:16])   + 20'(cfg.dest_ip[15:0]);
   assign fold_1   = 17'(sum_raw[15:0]) + 17'(sum_raw[19:16]);
   assign fold_2   = 17'(fold_1[15:0]) + 17'(fold_1[16]);
   assign checksum = ~fold_2[15:0];

   always_comb begin
      hdr.words[0] = {cfg.dest_mac, cfg.source_mac[47:32]};
      hdr.words[1] = {cfg.source_mac[31:0], EtherTypeIpv4, IpVersionIhl, IpTos};
      hdr.words[2] = {ip_len, IpIdent, IpFlagsFrag, IpTtl, IpProtoUdp};
      hdr.words[3] = {checksum, cfg.source_ip, cfg.dest_ip[31:16]};
      hdr.words[4] = {cfg.dest_ip[15:0], cfg.source_port, cfg.dest_port, udp_len};
      hdr.words[5] = {UdpChecksum, CustomMagic, req.target_address[63:32]};
      hdr.words[6] = {req.target_address[31:0], 32'h0};
      hdr.words[7] = '0;
      hdr.length_error = (req.payload_bytes > MaxPayload);
   end

endmodule

// ===== src/ufhb_beat_out.sv =====
// ----------------------------------------------------------------------------
// ufhb_beat_out
// Hold one built header and send it as eight beats, one per cycle.
// ----------------------------------------------------------------------------
module ufhb_beat_out
   import ufhb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  hdr_type hdr,
   output logic    free,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   hdr_type                hdr_ff;
   logic [BeatIdxBits-1:0] beat_ff;
   logic [BeatIdxBits-1:0] beat_in;
   logic                   active_ff;
   logic                   active_in;
   logic                   on_last;

   assign on_last = active_ff && (beat_ff == LastBeat);
   // free when idle or sending the final beat
   assign free    = !active_ff || on_last;

   always_comb begin
      beat_in   = beat_ff;
      active_in = active_ff;
      if (load) begin
         beat_in   = '0;
         active_in = 1'b1;
      end else if (on_last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         beat_in = beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         beat_ff   <= beat_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hdr_ff <= hdr;
      end
   end

   assign rsp_valid             = active_ff;
   assign rsp_data.header_word  = hdr_ff.words[beat_ff];
   assign rsp_data.last_word    = (beat_ff == LastBeat);
   assign rsp_data.length_error = hdr_ff.length_error;

endmodule
